[hw/rtl/pcm_dmx_pkg.sv]
// Shared types, codes and constants of the PCM downmix resampler.
package pcm_dmx_pkg;

   localparam int NUM_WORDS    = 8;
   localparam int PER_INTERVAL = 8;
   localparam int WORD_W       = 32;

   localparam logic [1:0] FMT_INT16 = 2'd0;
   localparam logic [1:0] FMT_INT24 = 2'd1;
   localparam logic [1:0] FMT_FLOAT = 2'd2;

   localparam logic [1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_FORMAT = 2'd1;
   localparam logic [1:0] CSR_PHASE_STEP    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_PROD,
      ST_ROUND,
      ST_ICHK,
      ST_IOUT,
      ST_TAIL
   } state_type;

   typedef struct packed {
      logic sum_en;
      logic prod_en;
      logic cur_en;
   } merge_ctl_type;

   // round(65536 / n)
   function automatic logic [16:0] recip_q16(input logic [3:0] n);
      logic [16:0] r;
      unique case (n)
         4'd0, 4'd1: r = 17'd65536;
         4'd2:  r = 17'd32768;
         4'd3:  r = 17'd21845;
         4'd4:  r = 17'd16384;
         4'd5:  r = 17'd13107;
         4'd6:  r = 17'd10923;
         4'd7:  r = 17'd9362;
         4'd8:  r = 17'd8192;
         4'd9:  r = 17'd7282;
         4'd10: r = 17'd6554;
         4'd11: r = 17'd5958;
         4'd12: r = 17'd5461;
         4'd13: r = 17'd5041;
         4'd14: r = 17'd4681;
         default: r = 17'd4369;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/pcm_downmix_linear_resampler_unit.sv]
// Top level: PCM downmix lanes, merge stage and interpolating output sequencer.
//
//   channel   dir  handshake            payload
//   req_      in   tvalid/tready        tdata = 8 channel words, tlast = frame_last
//   rsp_      out  tvalid/tready        tdata = mono_sample, tlast = run_last
//   csr_      in   we (no wait)         index, wdata
//
// A frame passes through lanes and merge as accept, sum, scale and round, then each
// interpolated result passes a check-and-multiply state and the output register,
// each repeated tail result the tail state, and each of the two loops ends in a
// closing state.
// Frames are taken one at a time; req_tready is high only when the sequencer idles.
// A stalled rsp_ side holds the sequencer at the output register or in the tail state.
// reset is synchronous, loads configuration defaults and clears phase and clip state.
module pcm_downmix_linear_resampler_unit #(
   parameter int MAX_CHANNELS = 8,
   parameter int FRAC_BITS    = 24,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // chan0_word .. chan7_word, 32 bits each, from bit 0 up
   input  logic [pcm_dmx_pkg::NUM_WORDS*32-1:0] req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // mono_sample, zero-filled to whole bytes
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [1:0]                           csr_index,
   input  logic [31:0]                          csr_wdata
);
   import pcm_dmx_pkg::*;

   localparam int LANES = (MAX_CHANNELS < NUM_WORDS) ? MAX_CHANNELS : NUM_WORDS;
   localparam int RSP_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int OFS_W = 34;
   localparam int IPR_W = SAMPLE_BITS + FRAC_BITS + 2;
   localparam logic [OFS_W-1:0] ONE = OFS_W'(1) << FRAC_BITS;

   // configuration
   logic [3:0]  channel_count_ff;
   logic [1:0]  sample_format_ff;
   logic [31:0] phase_step_ff;

   // clip state
   logic signed [SAMPLE_BITS-1:0] prev_ff;
   logic [OFS_W-1:0]              off_ff;
   logic                          have_prev_ff;
   logic [3:0]                    k_ff;
   logic                          last_ff;

   state_type state_ff, state_in;

   logic signed [SAMPLE_BITS-1:0] lane_sample [LANES];
   logic signed [SAMPLE_BITS-1:0] cur;
   logic [3:0]                    n_eff;
   merge_ctl_type                 mctl;

   logic signed [IPR_W-1:0]       ipr_ff;
   logic signed [SAMPLE_BITS:0]   diff;
   logic signed [SAMPLE_BITS-1:0] interp_val;

   logic [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_last_ff;

   logic             accept, slot_free, run_i, run_t, k_more;
   logic [OFS_W-1:0] off_step;
   logic             lane_load, ipr_load, rsp_load, sel_interp, rsp_last_in;
   logic             step_off, adj_off, finish;

   always_comb begin
      if (channel_count_ff == 4'd0) n_eff = 4'd1;
      else if (channel_count_ff > 4'(LANES)) n_eff = 4'(LANES);
      else n_eff = channel_count_ff;
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      pcm_dmx_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
         .clock         (clock),
         .load          (lane_load),
         .enable        (4'(g) < n_eff),
         .sample_format (sample_format_ff),
         .word          (req_tdata[g*32 +: 32]),
         .sample        (lane_sample[g])
      );
   end

   pcm_dmx_merge #(.LANES(LANES), .SAMPLE_BITS(SAMPLE_BITS)) u_merge (
      .clock   (clock),
      .ctl     (mctl),
      .count   (n_eff),
      .samples (lane_sample),
      .cur     (cur)
   );

   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign off_step  = off_ff + OFS_W'(phase_step_ff);
   assign k_more    = k_ff < 4'(PER_INTERVAL - 1);
   assign run_i     = have_prev_ff && (k_ff < 4'(PER_INTERVAL)) && (off_ff < ONE);
   assign run_t     = last_ff && (k_ff < 4'(PER_INTERVAL)) && (off_ff < ONE);

   // interpolation: prev + floor((cur - prev) * frac / 2^FRAC_BITS)
   assign diff       = $signed({cur[SAMPLE_BITS-1], cur}) - $signed({prev_ff[SAMPLE_BITS-1], prev_ff});
   assign interp_val = prev_ff + SAMPLE_BITS'(ipr_ff >>> FRAC_BITS);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_SUM;
         ST_SUM:   state_in = ST_PROD;
         ST_PROD:  state_in = ST_ROUND;
         ST_ROUND: state_in = ST_ICHK;
         ST_ICHK:  state_in = run_i ? ST_IOUT : ST_TAIL;
         ST_IOUT:  if (slot_free) state_in = ST_ICHK;
         ST_TAIL:  if (!run_t) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      lane_load   = 1'b0;
      mctl        = '0;
      ipr_load    = 1'b0;
      rsp_load    = 1'b0;
      sel_interp  = 1'b0;
      rsp_last_in = 1'b0;
      step_off    = 1'b0;
      adj_off     = 1'b0;
      finish      = 1'b0;
      unique case (state_ff)
         ST_IDLE:  lane_load = accept;
         ST_SUM:   mctl.sum_en = 1'b1;
         ST_PROD:  mctl.prod_en = 1'b1;
         ST_ROUND: mctl.cur_en = 1'b1;
         ST_ICHK: begin
            if (run_i) ipr_load = 1'b1;
            else if (have_prev_ff) adj_off = 1'b1;
         end
         ST_IOUT: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               sel_interp  = 1'b1;
               // last of the frame when the loop stops here and a last frame's
               // tail has no position left below one after the wrap
               rsp_last_in = !(k_more && (off_step < ONE))
                             && !(last_ff && (off_step < (ONE << 1)));
               step_off    = 1'b1;
            end
         end
         ST_TAIL: begin
            if (!run_t) begin
               finish = 1'b1;
            end else if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_last_in = !(k_more && (off_step < ONE));
               step_off    = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         channel_count_ff <= 4'd2;
         sample_format_ff <= FMT_INT16;
         phase_step_ff    <= 32'd50331648;
         prev_ff          <= '0;
         off_ff           <= '0;
         have_prev_ff     <= 1'b0;
         k_ff             <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[3:0];
               CSR_SAMPLE_FORMAT: sample_format_ff <= csr_wdata[1:0];
               CSR_PHASE_STEP:    phase_step_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (step_off) begin
            off_ff <= off_step;
            k_ff   <= k_ff + 4'd1;
         end
         if (adj_off) begin
            off_ff <= ((off_ff < ONE) ? ONE : off_ff) - ONE;
            k_ff   <= '0;
         end
         if (finish) begin
            k_ff <= '0;
            if (last_ff) begin
               prev_ff      <= '0;
               off_ff       <= '0;
               have_prev_ff <= 1'b0;
            end else begin
               prev_ff      <= cur;
               have_prev_ff <= 1'b1;
            end
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) last_ff <= req_tlast;
      if (ipr_load) ipr_ff <= IPR_W'(diff) * IPR_W'($signed({1'b0, off_ff[FRAC_BITS-1:0]}));
      if (rsp_load) begin
         rsp_sample_ff <= sel_interp ? interp_val : cur;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_sample_ff);
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= 4'(PER_INTERVAL))
      else $error("per-interval result count overran");

   a_iout_prev: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IOUT |-> have_prev_ff)
      else $error("interpolation without a previous frame");

   a_clip_end: assert property (@(posedge clock) disable iff (reset)
      finish && last_ff |=> !have_prev_ff && off_ff == '0 && state_ff == ST_IDLE)
      else $error("clip state not cleared after last frame");
`endif

endmodule

[hw/rtl/pcm_dmx_lane.sv]
// One decode lane: raw channel word to a signed fixed-point sample.
module pcm_dmx_lane #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          enable,
   input  logic [1:0]                    sample_format,
   input  logic [31:0]                   word,
   output logic signed [SAMPLE_BITS-1:0] sample
);
   import pcm_dmx_pkg::*;

   localparam int SH_L16 = SAMPLE_BITS - 16;
   localparam int SH_L24 = (SAMPLE_BITS >= 24) ? SAMPLE_BITS - 24 : 0;
   localparam int SH_R24 = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
   localparam logic signed [34:0] SMAX = 35'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [34:0] SMIN = -SMAX - 35'sd1;

   logic signed [31:0]            i16;
   logic signed [31:0]            i24;
   logic [7:0]                    expo;
   logic [23:0]                   sig;
   logic signed [10:0]            sh;
   logic signed [10:0]            nsh;
   logic [32:0]                   mag;
   logic                          sat;
   logic signed [34:0]            fval;
   logic signed [34:0]            fclamp;
   logic signed [SAMPLE_BITS-1:0] dec;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   always_comb begin
      i16  = 32'(signed'(word[15:0])) <<< SH_L16;
      i24  = (32'(signed'(word[23:0])) <<< SH_L24) >>> SH_R24;
      expo = word[30:23];
      sig  = {(expo != 8'd0), word[22:0]};
      sh   = $signed({3'b000, ((expo != 8'd0) ? expo : 8'd1)}) - 11'sd150
             + 11'(SAMPLE_BITS - 1);
      nsh  = -sh;
      mag  = '0;
      sat  = 1'b0;
      if (sh >= 11'sd9) begin
         sat = 1'b1;
      end else if (sh >= 11'sd0) begin
         mag = {9'b0, sig} << sh[3:0];
      end else if (sh > -11'sd25) begin
         mag = {9'b0, sig >> nsh[4:0]};
      end
      fval = word[31] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      if (expo == 8'hFF) begin
         if (word[22:0] != 23'd0) fclamp = '0;
         else fclamp = word[31] ? SMIN : SMAX;
      end else if (sat) begin
         fclamp = word[31] ? SMIN : SMAX;
      end else if (fval > SMAX) begin
         fclamp = SMAX;
      end else if (fval < SMIN) begin
         fclamp = SMIN;
      end else begin
         fclamp = fval;
      end
      unique case (sample_format)
         FMT_INT16: dec = SAMPLE_BITS'(i16);
         FMT_INT24: dec = SAMPLE_BITS'(i24);
         FMT_FLOAT: dec = SAMPLE_BITS'(fclamp);
         default:   dec = '0;
      endcase
      sample_in = enable ? dec : '0;
   end

   always_ff @(posedge clock) begin
      if (load) sample_ff <= sample_in;
   end

   assign sample = sample_ff;

endmodule

[hw/rtl/pcm_dmx_merge.sv]
// Merge stage: sums the lanes, scales by 1/n, rounds and saturates.
module pcm_dmx_merge #(
   parameter int LANES       = 8,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                              clock,
   input  pcm_dmx_pkg::merge_ctl_type        ctl,
   input  logic [3:0]                        count,
   input  logic signed [SAMPLE_BITS-1:0]     samples [LANES],
   output logic signed [SAMPLE_BITS-1:0]     cur
);
   import pcm_dmx_pkg::*;

   localparam int SUM_W  = SAMPLE_BITS + $clog2(LANES) + 1;
   localparam int PROD_W = SUM_W + 18;
   localparam logic signed [PROD_W-1:0] SMAX = PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [PROD_W-1:0] SMIN = -SMAX - PROD_W'(1);

   logic signed [SUM_W-1:0]       sum_in;
   logic signed [SUM_W-1:0]       sum_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [PROD_W-1:0]      rnd;
   logic signed [SAMPLE_BITS-1:0] cur_in;
   logic signed [SAMPLE_BITS-1:0] cur_ff;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < LANES; i++) sum_in = sum_in + SUM_W'(samples[i]);
      rnd = (prod_ff + PROD_W'(32768)) >>> 16;
      if (rnd > SMAX) cur_in = SAMPLE_BITS'(SMAX);
      else if (rnd < SMIN) cur_in = SAMPLE_BITS'(SMIN);
      else cur_in = SAMPLE_BITS'(rnd);
   end

   always_ff @(posedge clock) begin
      if (ctl.sum_en) sum_ff <= sum_in;
      if (ctl.prod_en) prod_ff <= PROD_W'(sum_ff) * PROD_W'($signed({1'b0, recip_q16(count)}));
      if (ctl.cur_en) cur_ff <= cur_in;
   end

   assign cur = cur_ff;

endmodule
